// File: rtl/pbrc_pkg.sv
// Package for the pulse beat rate classifier: widths, register map,
// reset values, class codes and the structs shared between modules.
// No dependencies.
`timescale 1ns / 1ps

package pbrc_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int ELAPSED_W = 12;
    localparam int THR_W     = 4;
    localparam int TIMER_W   = 16;
    localparam int RATE_W    = 14;
    localparam int SCALE_W   = 6;
    localparam int CLASS_W   = 2;
    localparam int BEATS_W   = 8;
    localparam int RUN_W     = 4;

    // Default depth of the moving sum
    localparam int AVERAGE_DEPTH_DEF = 4;

    // Configuration port
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RISE_THR   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LEN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RATE_SCALE = 3'd5;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_MIN_LEVEL  = 10'd500;
    localparam logic [THR_W-1:0]    RST_RISE_THR   = 4'd4;
    localparam logic [TIMER_W-1:0]  RST_WIN_LEN    = 16'd5000;
    localparam logic [RATE_W-1:0]   RST_LOW_LIMIT  = 14'd60;
    localparam logic [RATE_W-1:0]   RST_HIGH_LIMIT = 14'd100;
    localparam logic [SCALE_W-1:0]  RST_RATE_SCALE = 6'd6;

    // Rate classes
    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_LOW    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HIGH   = 2'd3;

    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
    localparam logic [BEATS_W-1:0] BEATS_MAX = '1;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] min_level;
        logic [THR_W-1:0]    rise_thr;
        logic [TIMER_W-1:0]  win_len;
        logic [RATE_W-1:0]   low_limit;
        logic [RATE_W-1:0]   high_limit;
        logic [SCALE_W-1:0]  rate_scale;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample_value;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } t_in_word;

    typedef struct packed {
        logic               beat_found;
        logic               signal_absent;
        logic               window_done;
        logic [RATE_W-1:0]  rate_bpm;
        logic [CLASS_W-1:0] rate_class;
        logic               pulse_lost;
    } t_result;

endpackage

// File: rtl/pbrc_if.sv
// Stream channels of the pulse beat rate classifier: sample words in,
// result words out. Depends on pbrc_pkg.
`timescale 1ns / 1ps

interface pbrc_in_if;
    logic                           valid;
    logic                           ready;
    logic [pbrc_pkg::SAMPLE_W-1:0]  sample_value;
    logic [pbrc_pkg::ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, output sample_value, output elapsed_ms, input ready);
    modport sink   (input valid, input sample_value, input elapsed_ms, output ready);
endinterface

interface pbrc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         beat_found;
    logic                         signal_absent;
    logic                         window_done;
    logic [pbrc_pkg::RATE_W-1:0]  rate_bpm;
    logic [pbrc_pkg::CLASS_W-1:0] rate_class;
    logic                         pulse_lost;

    modport source (
        output valid, output beat_found, output signal_absent, output window_done,
        output rate_bpm, output rate_class, output pulse_lost, input ready
    );
    modport sink (
        input valid, input beat_found, input signal_absent, input window_done,
        input rate_bpm, input rate_class, input pulse_lost, output ready
    );
endinterface

// File: rtl/pbrc_cfg.sv
// Configuration register file with APB-style write and read access.
// Depends on pbrc_pkg.
`timescale 1ns / 1ps

module pbrc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [pbrc_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [pbrc_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [pbrc_pkg::PDATA_W-1:0]   o_prdata,
    output logic                           o_pready,
    output pbrc_pkg::t_cfg                 o_cfg
);

    pbrc_pkg::t_cfg                    r_cfg;
    logic                              w_wr;
    logic [pbrc_pkg::REG_IDX_W-1:0]    w_idx;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_idx    = i_paddr[pbrc_pkg::PADDR_W-1:2];
    assign o_cfg    = r_cfg;

    // Write the addressed register, masked to its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_level  <= pbrc_pkg::RST_MIN_LEVEL;
            r_cfg.rise_thr   <= pbrc_pkg::RST_RISE_THR;
            r_cfg.win_len    <= pbrc_pkg::RST_WIN_LEN;
            r_cfg.low_limit  <= pbrc_pkg::RST_LOW_LIMIT;
            r_cfg.high_limit <= pbrc_pkg::RST_HIGH_LIMIT;
            r_cfg.rate_scale <= pbrc_pkg::RST_RATE_SCALE;
        end else if (w_wr) begin
            case (w_idx)
                pbrc_pkg::REG_MIN_LEVEL:  r_cfg.min_level  <= i_pwdata[pbrc_pkg::SAMPLE_W-1:0];
                pbrc_pkg::REG_RISE_THR:   r_cfg.rise_thr   <= i_pwdata[pbrc_pkg::THR_W-1:0];
                pbrc_pkg::REG_WIN_LEN:    r_cfg.win_len    <= i_pwdata[pbrc_pkg::TIMER_W-1:0];
                pbrc_pkg::REG_LOW_LIMIT:  r_cfg.low_limit  <= i_pwdata[pbrc_pkg::RATE_W-1:0];
                pbrc_pkg::REG_HIGH_LIMIT: r_cfg.high_limit <= i_pwdata[pbrc_pkg::RATE_W-1:0];
                pbrc_pkg::REG_RATE_SCALE: r_cfg.rate_scale <= i_pwdata[pbrc_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            pbrc_pkg::REG_MIN_LEVEL:  o_prdata = pbrc_pkg::PDATA_W'(r_cfg.min_level);
            pbrc_pkg::REG_RISE_THR:   o_prdata = pbrc_pkg::PDATA_W'(r_cfg.rise_thr);
            pbrc_pkg::REG_WIN_LEN:    o_prdata = pbrc_pkg::PDATA_W'(r_cfg.win_len);
            pbrc_pkg::REG_LOW_LIMIT:  o_prdata = pbrc_pkg::PDATA_W'(r_cfg.low_limit);
            pbrc_pkg::REG_HIGH_LIMIT: o_prdata = pbrc_pkg::PDATA_W'(r_cfg.high_limit);
            pbrc_pkg::REG_RATE_SCALE: o_prdata = pbrc_pkg::PDATA_W'(r_cfg.rate_scale);
            default:                  o_prdata = '0;
        endcase
    end

endmodule

// File: rtl/pbrc_core.sv
// Beat detection state and single-pass update: moving sum, rise run,
// window and lost timers, rate and class. Depends on pbrc_pkg.
`timescale 1ns / 1ps

module pbrc_core #(
    parameter int AVERAGE_DEPTH = pbrc_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  pbrc_pkg::t_in_word i_word,
    input  pbrc_pkg::t_cfg     i_cfg,
    output pbrc_pkg::t_result  o_result
);

    localparam int PTR_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SUM_W = pbrc_pkg::SAMPLE_W + $clog2(AVERAGE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVERAGE_DEPTH - 1);
    localparam int TW = pbrc_pkg::TIMER_W;

    logic [pbrc_pkg::SAMPLE_W-1:0] r_ring [AVERAGE_DEPTH];
    logic [PTR_W-1:0]              r_ptr,   n_ptr;
    logic [SUM_W-1:0]              r_sum,   n_sum;
    logic [SUM_W-1:0]              r_prev,  n_prev;
    logic                          r_rising, n_rising;
    logic [pbrc_pkg::RUN_W-1:0]    r_run,   n_run;
    logic [pbrc_pkg::BEATS_W-1:0]  r_beats, n_beats;
    logic [TW-1:0]                 r_wt,    n_wt;
    logic [TW-1:0]                 r_sb,    n_sb;

    logic [TW:0]                   w_wt_add, w_sb_add;
    logic [TW-1:0]                 w_wt_sat, w_sb_sat;
    logic [SUM_W-1:0]              w_sum;
    logic [pbrc_pkg::RUN_W-1:0]    w_run_inc;
    logic [pbrc_pkg::BEATS_W-1:0]  w_beats_b;
    logic [pbrc_pkg::RATE_W-1:0]   w_rate;
    logic                          w_absent, w_beat, w_done, w_lost;
    logic [pbrc_pkg::CLASS_W-1:0]  w_class;

    // Saturating timer advance
    assign w_wt_add = {1'b0, r_wt} + (TW+1)'(i_word.elapsed_ms);
    assign w_sb_add = {1'b0, r_sb} + (TW+1)'(i_word.elapsed_ms);
    assign w_wt_sat = w_wt_add[TW] ? pbrc_pkg::TIMER_MAX : w_wt_add[TW-1:0];
    assign w_sb_sat = w_sb_add[TW] ? pbrc_pkg::TIMER_MAX : w_sb_add[TW-1:0];

    // Drop the oldest reading and add the new one
    assign w_sum = r_sum - SUM_W'(r_ring[r_ptr]) + SUM_W'(i_word.sample_value);
    assign w_run_inc = (r_run == pbrc_pkg::RUN_MAX) ? r_run : r_run + 1'b1;
    assign w_absent  = i_word.sample_value < i_cfg.min_level;

    // Sample, window and lost steps in order
    always_comb begin
        n_ptr    = r_ptr;
        n_sum    = r_sum;
        n_prev   = r_prev;
        n_rising = r_rising;
        n_run    = r_run;
        n_beats  = r_beats;
        n_wt     = w_wt_sat;
        n_sb     = w_sb_sat;
        w_beat   = 1'b0;
        if (w_absent) begin
            n_rising = 1'b0;
            n_run    = '0;
        end else begin
            n_sum = w_sum;
            if (w_sum > r_prev) begin
                n_run = w_run_inc;
                if (!r_rising && (w_run_inc > i_cfg.rise_thr)) begin
                    n_rising = 1'b1;
                    n_sb     = '0;
                    w_beat   = 1'b1;
                    if (r_beats != pbrc_pkg::BEATS_MAX) begin
                        n_beats = r_beats + 1'b1;
                    end
                end
            end else begin
                n_rising = 1'b0;
                n_run    = '0;
            end
            n_prev = w_sum;
            n_ptr  = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
        end
        w_beats_b = n_beats;
        w_done = n_wt >= i_cfg.win_len;
        if (w_done) begin
            n_beats = '0;
            n_wt    = '0;
            n_prev  = '0;
        end
        w_lost = n_sb > i_cfg.win_len;
        if (w_lost) begin
            n_sb    = '0;
            n_wt    = '0;
            n_beats = '0;
        end
    end

    // Rate: 255 beats times scale 63 stays below the 14-bit ceiling
    assign w_rate = pbrc_pkg::RATE_W'(w_beats_b) * pbrc_pkg::RATE_W'(i_cfg.rate_scale);

    always_comb begin
        if (w_beats_b == '0) begin
            w_class = pbrc_pkg::CLASS_NONE;
        end else if (w_rate < i_cfg.low_limit) begin
            w_class = pbrc_pkg::CLASS_LOW;
        end else if (w_rate <= i_cfg.high_limit) begin
            w_class = pbrc_pkg::CLASS_NORMAL;
        end else begin
            w_class = pbrc_pkg::CLASS_HIGH;
        end
    end

    assign o_result.beat_found    = w_beat;
    assign o_result.signal_absent = w_absent;
    assign o_result.window_done   = w_done;
    assign o_result.rate_bpm      = w_done ? w_rate : '0;
    assign o_result.rate_class    = w_done ? w_class : pbrc_pkg::CLASS_NONE;
    assign o_result.pulse_lost    = w_lost;

    // Commit state when the word leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_sum    <= '0;
            r_prev   <= '0;
            r_rising <= 1'b0;
            r_run    <= '0;
            r_beats  <= '0;
            r_wt     <= '0;
            r_sb     <= '0;
        end else if (i_adv) begin
            r_ptr    <= n_ptr;
            r_sum    <= n_sum;
            r_prev   <= n_prev;
            r_rising <= n_rising;
            r_run    <= n_run;
            r_beats  <= n_beats;
            r_wt     <= n_wt;
            r_sb     <= n_sb;
        end
    end

    // Ring of recent readings, written at the pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVERAGE_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else if (i_adv && !w_absent) begin
            r_ring[r_ptr] <= i_word.sample_value;
        end
    end

`ifndef SYNTHESIS
    a_lost_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && w_lost |=> r_sb == '0 && r_wt == '0 && r_beats == '0)
        else $error("lost pulse did not restart timers and count");

    a_absent_holds_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && w_absent |=> r_sum == $past(r_sum) && r_ptr == $past(r_ptr) && r_run == '0)
        else $error("absent sample changed the moving sum");
`endif

endmodule

// File: rtl/pulse_beat_rate_classifier_unit.sv
// Top level of the pulse beat rate classifier: input register, result
// register, configuration registers and the update core.
// Depends on pbrc_pkg, pbrc_if, pbrc_cfg and pbrc_core.
`timescale 1ns / 1ps

// Usage
//   i_in carries one sample word per sensor period: sample_value and the
//   milliseconds elapsed since the previous word. o_res returns exactly one
//   result word per sample word: beat, absent, window-done, rate, class, lost.
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   The APB-style port writes the six thresholds and limits at byte address
//   4*index; write them only while no word is in flight.
// Registers and throughput
//   A word lands in the input register at the edge that accepts it, and its
//   result lands in the result register at the edge that advances it out of
//   the input register, once the result register is free or being drained.
//   One word per cycle while the receiver keeps ready high; the whole state
//   update is a single pass of adds and compares between the two registers.
// Reset and stall
//   Synchronous active-low reset clears both registers, all detector state
//   and the configuration to its defaults. When the receiver holds ready low
//   the result register holds, one more word waits in the input register,
//   and then i_in.ready drops until the result is taken.
module pulse_beat_rate_classifier_unit #(
    parameter int AVERAGE_DEPTH = pbrc_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pbrc_in_if.sink                      i_in,
    pbrc_out_if.source                   o_res,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [pbrc_pkg::PADDR_W-1:0] i_paddr,
    input  logic [pbrc_pkg::PDATA_W-1:0] i_pwdata,
    output logic [pbrc_pkg::PDATA_W-1:0] o_prdata,
    output logic                         o_pready
);

    pbrc_pkg::t_cfg     w_cfg;
    pbrc_pkg::t_in_word r_in_word;
    pbrc_pkg::t_result  w_result, r_out;
    logic               r_in_valid, r_out_valid;
    logic               w_out_free, w_adv, w_in_take;

    pbrc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    pbrc_core #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_word   (r_in_word),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Handshake: advance when the result register is free or being drained
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take  = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word.sample_value <= i_in.sample_value;
            r_in_word.elapsed_ms   <= i_in.elapsed_ms;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.beat_found    = r_out.beat_found;
    assign o_res.signal_absent = r_out.signal_absent;
    assign o_res.window_done   = r_out.window_done;
    assign o_res.rate_bpm      = r_out.rate_bpm;
    assign o_res.rate_class    = r_out.rate_class;
    assign o_res.pulse_lost    = r_out.pulse_lost;

`ifndef SYNTHESIS
    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid && $stable(r_in_word))
        else $error("waiting input word lost while result stalled");

    a_rate_only_at_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.window_done |-> o_res.rate_bpm == '0 &&
            o_res.rate_class == pbrc_pkg::CLASS_NONE)
        else $error("rate reported outside window end");

    a_beat_not_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.beat_found && o_res.signal_absent))
        else $error("beat found on an absent sample");
`endif

endmodule

// File: tb/sv/pulse_beat_rate_classifier_unit_test.sv
// Self-checking bench for pulse_beat_rate_classifier_unit: random pulse trains,
// APB register phases and a scoreboard that predicts every result word.
// Depends on pbrc_pkg, pbrc_if and the RTL top level.
`timescale 1ns / 1ps

module pulse_beat_rate_classifier_unit_test;
    import pbrc_pkg::*;

    localparam int          DEPTH         = AVERAGE_DEPTH_DEF;
    localparam int          SUM_W         = SAMPLE_W + $clog2(AVERAGE_DEPTH_DEF);
    localparam int unsigned SAMPLE_TOP    = (1 << SAMPLE_W) - 1;
    localparam int unsigned ELAPSED_TOP   = (1 << ELAPSED_W) - 1;
    localparam int unsigned RATE_TOP      = (1 << RATE_W) - 1;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned STALL_LIMIT   = 4000;

    // Predicts the result word of each accepted sample word and checks it
    class beat_rate_scoreboard;
        t_cfg                 cfg;
        logic [SAMPLE_W-1:0]  ring [DEPTH];
        int unsigned          ring_pos;
        logic [SUM_W-1:0]     sum_now;
        logic [SUM_W-1:0]     sum_prev;
        bit                   rising;
        logic [RUN_W-1:0]     run_len;
        logic [BEATS_W-1:0]   beats;
        logic [TIMER_W-1:0]   win_timer;
        logic [TIMER_W-1:0]   quiet_ms;
        t_result              expected_reports [$];
        int unsigned          mismatches;

        function new();
            cfg = {RST_MIN_LEVEL, RST_RISE_THR, RST_WIN_LEN,
                   RST_LOW_LIMIT, RST_HIGH_LIMIT, RST_RATE_SCALE};
            foreach (ring[k]) ring[k] = '0;
            ring_pos   = 0;
            sum_now    = '0;
            sum_prev   = '0;
            rising     = 1'b0;
            run_len    = '0;
            beats      = '0;
            win_timer  = '0;
            quiet_ms   = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_MIN_LEVEL:  cfg.min_level  = value[SAMPLE_W-1:0];
                REG_RISE_THR:   cfg.rise_thr   = value[THR_W-1:0];
                REG_WIN_LEN:    cfg.win_len    = value[TIMER_W-1:0];
                REG_LOW_LIMIT:  cfg.low_limit  = value[RATE_W-1:0];
                REG_HIGH_LIMIT: cfg.high_limit = value[RATE_W-1:0];
                REG_RATE_SCALE: cfg.rate_scale = value[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TIMER_W-1:0] sat_timer(logic [TIMER_W-1:0] t,
                                               logic [ELAPSED_W-1:0] e);
            logic [TIMER_W:0] s;
            s = t + e;
            return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
        endfunction

        function string describe(t_result r);
            return $sformatf("beat %0d absent %0d done %0d rate %0d class %0d lost %0d",
                             r.beat_found, r.signal_absent, r.window_done,
                             r.rate_bpm, r.rate_class, r.pulse_lost);
        endfunction

        // Advance the detector by one sample word and queue the result it causes
        function void note_sample(t_in_word w);
            t_result     r;
            int unsigned rate;
            r = '0;
            win_timer = sat_timer(win_timer, w.elapsed_ms);
            quiet_ms  = sat_timer(quiet_ms, w.elapsed_ms);

            if (w.sample_value < cfg.min_level) begin
                // no signal: drop the rise tracking
                r.signal_absent = 1'b1;
                rising  = 1'b0;
                run_len = '0;
            end else begin
                sum_now = sum_now - ring[ring_pos] + w.sample_value;
                ring[ring_pos] = w.sample_value;
                if (sum_now > sum_prev) begin
                    if (run_len != RUN_MAX) run_len++;
                    if (!rising && run_len > cfg.rise_thr) begin
                        rising   = 1'b1;
                        quiet_ms = '0;
                        if (beats != BEATS_MAX) beats++;
                        r.beat_found = 1'b1;
                    end
                end else begin
                    rising  = 1'b0;
                    run_len = '0;
                end
                sum_prev = sum_now;
                ring_pos = (ring_pos + 1) % DEPTH;
            end

            // window end: report rate and class, restart the count
            if (win_timer >= cfg.win_len) begin
                r.window_done = 1'b1;
                rate = int'(beats) * int'(cfg.rate_scale);
                if (rate > RATE_TOP) rate = RATE_TOP;
                r.rate_bpm = RATE_W'(rate);
                if (beats == 0)                 r.rate_class = CLASS_NONE;
                else if (rate < cfg.low_limit)  r.rate_class = CLASS_LOW;
                else if (rate <= cfg.high_limit) r.rate_class = CLASS_NORMAL;
                else                            r.rate_class = CLASS_HIGH;
                beats     = '0;
                win_timer = '0;
                sum_prev  = '0;
            end

            // no beat for longer than a window: flag lost and restart
            if (quiet_ms > cfg.win_len) begin
                r.pulse_lost = 1'b1;
                quiet_ms  = '0;
                win_timer = '0;
                beats     = '0;
            end
            expected_reports.push_back(r);
        endfunction

        // Compare a result word with the oldest prediction
        function void check_report(t_result got);
            t_result want;
            bit      bad;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result word with nothing predicted: %s",
                             $realtime, describe(got));
                return;
            end
            want = expected_reports.pop_front();
            bad = (got.beat_found    !== want.beat_found)    ||
                  (got.signal_absent !== want.signal_absent) ||
                  (got.window_done   !== want.window_done)   ||
                  (got.rate_bpm      !== want.rate_bpm)      ||
                  (got.rate_class    !== want.rate_class)    ||
                  (got.pulse_lost    !== want.pulse_lost);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                             $realtime, describe(want), describe(got));
            end
        endfunction

        function bit failed();
            return (mismatches != 0) || (expected_reports.size() != 0);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_psel;
    logic                 i_penable;
    logic                 i_pwrite;
    logic [PADDR_W-1:0]   i_paddr;
    logic [PDATA_W-1:0]   i_pwdata;
    logic [PDATA_W-1:0]   o_prdata;
    logic                 o_pready;

    pbrc_in_if  in_if ();
    pbrc_out_if res_if ();

    beat_rate_scoreboard board;

    int unsigned          words_sent = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          hold_asks = 0;
    int unsigned          cur_min = RST_MIN_LEVEL;
    int unsigned          cur_thr = RST_RISE_THR;
    int unsigned          cur_win = RST_WIN_LEN;

    pulse_beat_rate_classifier_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_res     (res_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always begin
        #4 i_clk = ~i_clk;
    end

    // Score every word that moves on either channel
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            board.note_sample({in_if.sample_value, in_if.elapsed_ms});
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_report({res_if.beat_found, res_if.signal_absent, res_if.window_done,
                                res_if.rate_bpm, res_if.rate_class, res_if.pulse_lost});
        end
    end

    // Result receiver: random stalls, plus a long hold when one is asked for
    initial begin : receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
                (i_psel && i_penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("pulse_beat_rate_classifier_unit regression: fail");
        $finish;
    end

    // Offer one sample word, idling first at random, and hold it until taken
    task automatic send_word(input int unsigned sample, input int unsigned elapsed);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_value <= SAMPLE_W'(sample);
        in_if.elapsed_ms   <= ELAPSED_W'(elapsed);
        do @(posedge i_clk); while (!in_if.ready);
        words_sent++;
    endtask

    // APB write: setup then access; junk above the register width must be dropped
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value,
                             input int unsigned width);
        logic [PDATA_W-1:0] word;
        word = PDATA_W'(value) | (PDATA_W'($urandom) << width);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= word;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        board.set_reg(idx, word);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait for every predicted result word to come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (board.expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly short steps sized to the window, sometimes none, sometimes anything
    function automatic int unsigned pick_elapsed();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        span = cur_win / 16 + 1;
        if (span > ELAPSED_TOP) span = ELAPSED_TOP;
        if (pick < 6) return 0;
        if (pick < 10) return $urandom_range(ELAPSED_TOP);
        return $urandom_range(span, 1);
    endfunction

    // One pulse: a ramp up from a random base, then a ramp down, now and then
    // broken by a dropout below the signal level
    task automatic send_pulse();
        int unsigned base;
        int unsigned stride;
        int unsigned level;
        int unsigned rise_len;
        int unsigned fall_len;
        base     = cur_min + $urandom_range((SAMPLE_TOP - cur_min) / 2);
        stride   = $urandom_range(60, 1);
        rise_len = ($urandom_range(9) == 0) ? $urandom_range(18, 1)
                                             : $urandom_range(cur_thr + 4, 1);
        fall_len = $urandom_range(8, 1);
        level    = base;
        repeat (rise_len) begin
            level = (level + stride > SAMPLE_TOP) ? SAMPLE_TOP : level + stride;
            send_word(level, pick_elapsed());
        end
        repeat (fall_len) begin
            level = (level < cur_min + stride) ? cur_min : level - stride;
            if (cur_min > 0 && $urandom_range(19) == 0)
                send_word($urandom_range(cur_min - 1), pick_elapsed());
            else
                send_word(level, pick_elapsed());
        end
    endtask

    // One register setting and a stretch of random traffic under it
    task automatic run_phase(input t_cfg s, input int unsigned words,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input bit stall_sink, input bit drain_midway);
        int unsigned target;
        int unsigned half;
        int unsigned pick;
        bit          midway_done;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(REG_MIN_LEVEL,  s.min_level,  SAMPLE_W);
        write_reg(REG_RISE_THR,   s.rise_thr,   THR_W);
        write_reg(REG_WIN_LEN,    s.win_len,    TIMER_W);
        write_reg(REG_LOW_LIMIT,  s.low_limit,  RATE_W);
        write_reg(REG_HIGH_LIMIT, s.high_limit, RATE_W);
        write_reg(REG_RATE_SCALE, s.rate_scale, SCALE_W);
        cur_min = s.min_level;
        cur_thr = s.rise_thr;
        cur_win = s.win_len;
        target  = words_sent + words;
        half    = words_sent + words / 2;
        midway_done = 1'b0;
        while (words_sent < target) begin
            if (!midway_done && words_sent >= half) begin
                midway_done = 1'b1;
                if (stall_sink) hold_asks++;
                if (drain_midway) wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_pulse();
            end else if (pick < 88) begin
                repeat ($urandom_range(6, 1)) send_word($urandom_range(SAMPLE_TOP), pick_elapsed());
            end else begin
                repeat ($urandom_range(4, 1))
                    send_word(cur_min == 0 ? 0 : $urandom_range(cur_min - 1), pick_elapsed());
            end
        end
        wait_drained();
    endtask

    initial begin : stimulus
        board = new();
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.sample_value = '0;
        in_if.elapsed_ms   = '0;
        i_psel             = 1'b0;
        i_penable          = 1'b0;
        i_pwrite           = 1'b0;
        i_paddr            = '0;
        i_pwdata           = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings
        send_idle_pct = 16;
        recv_idle_pct = 59;
        send_word(0, 0);
        send_word(SAMPLE_TOP, ELAPSED_TOP);
        send_word(RST_MIN_LEVEL - 1, 0);
        // at the signal level; the window ends with no beats and the pulse is lost
        send_word(RST_MIN_LEVEL, ELAPSED_TOP);
        // a clean ramp long enough for one beat, a plateau, then a fall
        for (int k = 0; k < 8; k++) send_word(600 + 50 * k, 10);
        repeat (2) send_word(SAMPLE_TOP, 10);
        for (int k = 0; k < 4; k++) send_word(900 - 100 * k, 10);
        // close the window holding that one beat
        send_word(700, 4000);
        send_word(700, 1000);
        wait_drained();

        // Field order: min level, rise threshold, window, low limit, high limit, scale
        run_phase({10'd500, 4'd4, 16'd5000, 14'd60, 14'd100, 6'd6}, 400, 16, 59, 1'b0, 1'b0);
        // lowest values; a zero scale makes beats classed on a rate of zero
        run_phase({10'd0, 4'd0, 16'd1, 14'd0, 14'd0, 6'd0}, 250, 16, 59, 1'b1, 1'b0);
        run_phase({10'd200, 4'd1, 16'd3000, 14'd40, 14'd60, 6'd20}, 400, 59, 16, 1'b0, 1'b0);
        // highest values but a rise threshold of fourteen; timers reach saturation
        run_phase({10'd1023, 4'd14, 16'd65535, 14'd16383, 14'd16383, 6'd63}, 150, 59, 16,
                  1'b0, 1'b1);
        run_phase({10'd300, 4'd2, 16'd800, 14'd20, 14'd200, 6'd63}, 500, 0, 0, 1'b0, 1'b0);
        // a threshold of fifteen never finds a beat; a zero window ends on every word
        run_phase({10'd100, 4'd15, 16'd0, 14'd5, 14'd10, 6'd1}, 150, 0, 0, 1'b0, 1'b0);

        if (board.failed()) begin
            $display("pulse_beat_rate_classifier_unit regression: fail");
        end else begin
            $display("pulse_beat_rate_classifier_unit regression: pass");
        end
        $finish;
    end

endmodule
